>>> src/mrcs_pkg.sv
`timescale 1ns / 1ps
// Package for the matrix row/column sum and argmax unit.
// Holds shared widths, default sizes, result kind codes and the cell control struct.
// No dependencies.
package mrcs_pkg;

	localparam int SUM_W        = 22;
	localparam int POS_W        = 7;
	localparam int KIND_W       = 2;
	localparam int ROWS_REG_W   = 7;
	localparam int COLS_REG_W   = 5;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_INDEX_W  = 1;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 16;
	localparam int DEF_ELEM_W   = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ROW_SUM  = 2'd0,
		KIND_COL_SUM  = 2'd1,
		KIND_BEST_ROW = 2'd2,
		KIND_BEST_COL = 2'd3
	} kind_t;

	// Control shared by every column cell in one cycle.
	typedef struct packed {
		logic add_en;
		logic shift_en;
		logic clear;
	} cell_ctl_t;

endpackage

>>> src/mrcs_elem_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one matrix element per beat.
// Depends on mrcs_pkg.
interface mrcs_elem_if import mrcs_pkg::*; #(
	parameter int ELEM_W = DEF_ELEM_W
);
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element;

	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

>>> src/mrcs_res_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one result per beat.
// Depends on mrcs_pkg.
interface mrcs_res_if import mrcs_pkg::*;;
	logic                    valid;
	logic                    ready;
	kind_t                   kind;
	logic [POS_W-1:0]        position;
	logic signed [SUM_W-1:0] total;
	logic                    last;

	modport source (output valid, output kind, output position, output total, output last,
		input ready);
	modport sink   (input valid, input kind, input position, input total, input last,
		output ready);
endinterface

>>> src/mrcs_cell.sv
`timescale 1ns / 1ps
// One column cell: holds a column sum, adds the broadcast element when selected,
// and passes its sum to its lower neighbor during the drain. Depends on mrcs_pkg.
module mrcs_cell import mrcs_pkg::*; #(
	parameter int COL_IDX = 0,
	parameter int SEL_W   = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic [SEL_W-1:0]        col_sel,
	input  logic signed [SUM_W-1:0] addend,
	input  logic signed [SUM_W-1:0] shift_in,
	output logic signed [SUM_W-1:0] sum
);

	logic signed [SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.shift_en) begin
			sum_q <= shift_in;
		end else if (ctl.add_en && (col_sel == SEL_W'(COL_IDX))) begin
			sum_q <= sum_q + addend;
		end
	end

	assign sum = sum_q;

endmodule

>>> src/matrix_row_column_sum_argmax_unit.sv
`timescale 1ns / 1ps
// Matrix row/column sum and argmax unit, top level.
// Depends on mrcs_pkg, mrcs_elem_if, mrcs_res_if and mrcs_cell.
//
// Usage: program num_rows (index 0) and num_cols (index 1) through the write
// port while the unit is idle, then stream matrix elements in row-major order
// on the elements channel, one beat per element. Results leave on the results
// channel. The last element of each row produces a row sum beat. The last
// element of the matrix is followed by one column sum beat per column, then
// the best row index beat and the best column index beat, which carries last.
//
// Throughput: one element per cycle inside a matrix. A row sum is in the
// output register in the cycle after the element that ends the row. After the
// final element the column cells drain one column per cycle through the head
// of the chain, then the best row and best column beats follow, and no
// element is taken meanwhile. The output register decouples the two sides: an
// element is accepted while a finished result waits, as long as that result
// is being taken in the same cycle or the register is empty. When the
// receiver stalls with a result pending, element intake and the drain hold.
// Reset sets both sizes to 1, clears every column sum and the row state, and
// empties the output register. Sums wrap modulo 2^22.
module matrix_row_column_sum_argmax_unit import mrcs_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int ELEM_W   = DEF_ELEM_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	mrcs_elem_if.sink              elements,
	mrcs_res_if.source             results
);

	// Row and column counters hold values up to the maximum size itself.
	localparam int RCW    = $clog2(MAX_ROWS + 1);
	localparam int CCW    = $clog2(MAX_COLS + 1);
	localparam int RCMP_W = (RCW > ROWS_REG_W) ? RCW : ROWS_REG_W;
	localparam int CCMP_W = (CCW > COLS_REG_W) ? CCW : COLS_REG_W;
	localparam int EXT_W  = (ELEM_W > SUM_W) ? ELEM_W : SUM_W;

	typedef enum logic [3:0] {
		ST_ACCUM = 4'b0001,
		ST_COLS  = 4'b0010,
		ST_BROW  = 4'b0100,
		ST_BCOL  = 4'b1000
	} state_t;

	state_t state_q;

	logic [ROWS_REG_W-1:0] num_rows_q;
	logic [COLS_REG_W-1:0] num_cols_q;

	logic [RCW-1:0]          row_count_q;
	logic [CCW-1:0]          col_count_q;
	logic [CCW-1:0]          walk_q;
	logic signed [SUM_W-1:0] row_sum_q;
	logic signed [SUM_W-1:0] best_row_sum_q;
	logic [RCW-1:0]          best_row_q;
	logic signed [SUM_W-1:0] best_col_sum_q;
	logic [CCW-1:0]          best_col_q;

	logic                    res_valid_q;
	kind_t                   res_kind_q;
	logic [POS_W-1:0]        res_pos_q;
	logic signed [SUM_W-1:0] res_total_q;
	logic                    res_last_q;

	// Effective sizes: zero counts as one, anything above the maximum is clamped.
	logic [RCMP_W-1:0] rows_req, rows_eff;
	logic [CCMP_W-1:0] cols_req, cols_eff;

	always_comb begin
		rows_req = RCMP_W'(num_rows_q);
		cols_req = CCMP_W'(num_cols_q);
		if (rows_req == '0) begin
			rows_eff = RCMP_W'(1);
		end else if (rows_req > RCMP_W'(MAX_ROWS)) begin
			rows_eff = RCMP_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_req;
		end
		if (cols_req == '0) begin
			cols_eff = CCMP_W'(1);
		end else if (cols_req > CCMP_W'(MAX_COLS)) begin
			cols_eff = CCMP_W'(MAX_COLS);
		end else begin
			cols_eff = cols_req;
		end
	end

	// The element is sign-extended (or wrapped) to the sum width.
	logic signed [EXT_W-1:0] elem_wide;
	logic signed [SUM_W-1:0] elem_sum;
	assign elem_wide = EXT_W'(elements.element);
	assign elem_sum  = elem_wide[SUM_W-1:0];

	logic                    out_free;
	logic                    accept_in;
	logic signed [SUM_W-1:0] row_sum_new;
	logic [CCW-1:0]          col_next;
	logic [RCW-1:0]          row_next;
	logic [CCW-1:0]          walk_next;
	logic                    row_end;
	logic                    matrix_end;
	logic                    walk_done;
	logic                    row_better;
	logic                    col_better;

	// Column cells form a chain; the head of the chain feeds the drain.
	cell_ctl_t               cell_ctl;
	logic signed [SUM_W-1:0] col_sums [MAX_COLS];

	assign out_free   = !res_valid_q || results.ready;
	assign elements.ready = (state_q == ST_ACCUM) && out_free;
	assign accept_in  = elements.valid && elements.ready;

	assign row_sum_new = row_sum_q + elem_sum;
	assign col_next    = col_count_q + CCW'(1);
	assign row_next    = row_count_q + RCW'(1);
	assign walk_next   = walk_q + CCW'(1);
	assign row_end     = CCMP_W'(col_next) >= cols_eff;
	assign matrix_end  = RCMP_W'(row_next) >= rows_eff;
	assign walk_done   = CCMP_W'(walk_next) >= cols_eff;
	assign row_better  = (best_row_q == '0) || (row_sum_new > best_row_sum_q);
	assign col_better  = (walk_q == '0) || (col_sums[0] > best_col_sum_q);

	always_comb begin
		cell_ctl.add_en   = accept_in;
		cell_ctl.shift_en = (state_q == ST_COLS) && out_free;
		cell_ctl.clear    = (state_q == ST_BCOL) && out_free;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_COLS; gi++) begin : g_cell
			logic signed [SUM_W-1:0] next_sum;
			if (gi == MAX_COLS - 1) begin : g_tail
				assign next_sum = '0;
			end else begin : g_mid
				assign next_sum = col_sums[gi+1];
			end
			mrcs_cell #(
				.COL_IDX (gi),
				.SEL_W   (CCW)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl),
				.col_sel  (col_count_q),
				.addend   (elem_sum),
				.shift_in (next_sum),
				.sum      (col_sums[gi])
			);
		end
	endgenerate

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= ROWS_REG_W'(1);
			num_cols_q <= COLS_REG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data;
				REG_NUM_COLS: num_cols_q <= cfg_data[COLS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Control and matrix state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ACCUM;
			row_count_q    <= '0;
			col_count_q    <= '0;
			walk_q         <= '0;
			row_sum_q      <= '0;
			best_row_sum_q <= '0;
			best_row_q     <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCUM: begin
					if (accept_in) begin
						if (!row_end) begin
							col_count_q <= col_next;
							row_sum_q   <= row_sum_new;
						end else begin
							res_valid_q <= 1'b1;
							col_count_q <= '0;
							row_sum_q   <= '0;
							if (row_better) begin
								best_row_sum_q <= row_sum_new;
								best_row_q     <= row_next;
							end
							row_count_q <= row_next;
							if (matrix_end) begin
								walk_q  <= '0;
								state_q <= ST_COLS;
							end
						end
					end
				end
				ST_COLS: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						walk_q      <= walk_next;
						if (walk_done) begin
							state_q <= ST_BROW;
						end
					end
				end
				ST_BROW: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_BCOL;
					end
				end
				ST_BCOL: begin
					if (out_free) begin
						// Best column goes out; the matrix state starts over.
						res_valid_q    <= 1'b1;
						row_count_q    <= '0;
						col_count_q    <= '0;
						row_sum_q      <= '0;
						best_row_sum_q <= '0;
						best_row_q     <= '0;
						state_q        <= ST_ACCUM;
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

	// Result payload and the running column maximum carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ACCUM: begin
				if (accept_in && row_end) begin
					res_kind_q  <= KIND_ROW_SUM;
					res_pos_q   <= POS_W'(row_next);
					res_total_q <= row_sum_new;
					res_last_q  <= 1'b0;
				end
			end
			ST_COLS: begin
				if (out_free) begin
					res_kind_q  <= KIND_COL_SUM;
					res_pos_q   <= POS_W'(walk_next);
					res_total_q <= col_sums[0];
					res_last_q  <= 1'b0;
					if (col_better) begin
						best_col_sum_q <= col_sums[0];
						best_col_q     <= walk_next;
					end
				end
			end
			ST_BROW: begin
				if (out_free) begin
					res_kind_q  <= KIND_BEST_ROW;
					res_pos_q   <= POS_W'(best_row_q);
					res_total_q <= '0;
					res_last_q  <= 1'b0;
				end
			end
			ST_BCOL: begin
				if (out_free) begin
					res_kind_q  <= KIND_BEST_COL;
					res_pos_q   <= POS_W'(best_col_q);
					res_total_q <= '0;
					res_last_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign results.valid    = res_valid_q;
	assign results.kind     = res_kind_q;
	assign results.position = res_pos_q;
	assign results.total    = res_total_q;
	assign results.last     = res_last_q;

endmodule

>>> src/mrcs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the matrix row/column sum and argmax unit, with its bind.
// Depends on mrcs_pkg and matrix_row_column_sum_argmax_unit.
module mrcs_checker import mrcs_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    elem_ready,
	input logic                    res_valid,
	input logic                    res_ready,
	input kind_t                   res_kind,
	input logic [POS_W-1:0]        res_position,
	input logic signed [SUM_W-1:0] res_total,
	input logic                    res_last
);

	// A stalled result beat stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
			&& $stable(res_position) && $stable(res_total) && $stable(res_last))
		else $error("result beat changed while stalled");

	// No element is taken while a result is stuck in the output register.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !elem_ready)
		else $error("element accepted while output register is blocked");

	// Only the best column beat closes a matrix.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_last |-> res_kind == KIND_BEST_COL)
		else $error("last flag on a result other than best column");

	// Index results carry a zero total.
	a_index_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_BEST_ROW || res_kind == KIND_BEST_COL)
			|-> res_total == '0)
		else $error("index result with nonzero total");

	// The best row beat is always followed by the best column beat.
	a_row_then_col: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_kind == KIND_BEST_ROW
			|=> res_valid && res_kind == KIND_BEST_COL)
		else $error("best row not followed by best column");

endmodule

bind matrix_row_column_sum_argmax_unit mrcs_checker u_mrcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.elem_ready   (elements.ready),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.res_kind     (results.kind),
	.res_position (results.position),
	.res_total    (results.total),
	.res_last     (results.last)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_row_column_sum_argmax_unit.
// Depends on mrcs_pkg, mrcs_elem_if, mrcs_res_if and the unit's RTL.
module tb;
	import mrcs_pkg::*;

	localparam int          CLK_HALF     = 5;
	localparam int          LIMIT_CYCLES = 200000;
	localparam int          HOLD_CYCLES  = 80;
	localparam int          SETTLE       = DEF_MAX_COLS + 4;
	localparam int unsigned ITEM_TARGET  = 360;

	// One result beat as seen on the results channel.
	typedef struct packed {
		kind_t                   kind;
		logic [POS_W-1:0]        position;
		logic signed [SUM_W-1:0] total;
		logic                    last;
	} result_t;

	// The class mirrors the unit: it folds every accepted element into its
	// own sums and keeps the resulting beats in arrival order.
	class sum_scoreboard;
		logic [ROWS_REG_W-1:0]   rows_reg;
		logic [COLS_REG_W-1:0]   cols_reg;
		logic signed [SUM_W-1:0] col_acc [DEF_MAX_COLS];
		logic signed [SUM_W-1:0] row_acc;
		logic signed [SUM_W-1:0] best_sum;
		int unsigned             row_idx;
		int unsigned             col_idx;
		int unsigned             best_row;
		result_t                 sums_due [$];
		int unsigned             mismatches;
		int unsigned             checked;
		int unsigned             matrices;

		function new();
			rows_reg   = 1;
			cols_reg   = 1;
			mismatches = 0;
			checked    = 0;
			matrices   = 0;
			clear_matrix();
		endfunction

		function void clear_matrix();
			foreach (col_acc[i]) col_acc[i] = '0;
			row_acc  = '0;
			best_sum = '0;
			row_idx  = 0;
			col_idx  = 0;
			best_row = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == REG_NUM_ROWS) rows_reg = data[ROWS_REG_W-1:0];
			else cols_reg = data[COLS_REG_W-1:0];
		endfunction

		function int unsigned eff_rows();
			if (rows_reg == 0) return 1;
			if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
			return rows_reg;
		endfunction

		function int unsigned eff_cols();
			if (cols_reg == 0) return 1;
			if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
			return cols_reg;
		endfunction

		function void push_beat(kind_t kind, int unsigned pos, logic signed [SUM_W-1:0] total,
				logic last);
			result_t r;
			r.kind     = kind;
			r.position = POS_W'(pos);
			r.total    = total;
			r.last     = last;
			sums_due.push_back(r);
		endfunction

		function void accumulate_element(logic signed [DEF_ELEM_W-1:0] value);
			int unsigned             cols;
			int unsigned             best_col;
			logic signed [SUM_W-1:0] best_col_sum;
			cols = eff_cols();
			row_acc = row_acc + value;
			if (col_idx < DEF_MAX_COLS) col_acc[col_idx] = col_acc[col_idx] + value;
			col_idx++;
			if (col_idx < cols) return;
			row_idx++;
			push_beat(KIND_ROW_SUM, row_idx, row_acc, 1'b0);
			if (best_row == 0 || row_acc > best_sum) begin
				best_sum = row_acc;
				best_row = row_idx;
			end
			row_acc = '0;
			col_idx = 0;
			if (row_idx < eff_rows()) return;
			best_col     = 1;
			best_col_sum = col_acc[0];
			for (int i = 0; i < cols; i++) begin
				push_beat(KIND_COL_SUM, i + 1, col_acc[i], 1'b0);
				if (col_acc[i] > best_col_sum) begin
					best_col_sum = col_acc[i];
					best_col     = i + 1;
				end
			end
			push_beat(KIND_BEST_ROW, best_row, '0, 1'b0);
			push_beat(KIND_BEST_COL, best_col, '0, 1'b1);
			matrices++;
			clear_matrix();
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (sums_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result kind=%0d pos=%0d total=%0d last=%0b",
						got.kind, got.position, got.total, got.last);
				return;
			end
			want = sums_due.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: result %0d expected kind=%0d pos=%0d total=%0d last=%0b,",
						" got kind=%0d pos=%0d total=%0d last=%0b"}, checked,
						want.kind, want.position, want.total, want.last,
						got.kind, got.position, got.total, got.last);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	mrcs_elem_if #(.ELEM_W(DEF_ELEM_W)) elem_bus ();
	mrcs_res_if                         res_bus ();

	matrix_row_column_sum_argmax_unit #(
		.MAX_ROWS(DEF_MAX_ROWS),
		.MAX_COLS(DEF_MAX_COLS),
		.ELEM_W  (DEF_ELEM_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.elements (elem_bus),
		.results  (res_bus)
	);

	sum_scoreboard sb;
	int unsigned   elements_sent = 0;
	int unsigned   size_settings = 0;
	int unsigned   send_burst    = 0;
	int unsigned   recv_burst    = 0;
	int unsigned   cycle_count   = 0;
	bit            hold_req      = 1'b0;

	always #CLK_HALF clk = ~clk;

	// Each side waits a random gap before each beat, except during occasional
	// bursts in which it never idles, so back-to-back traffic is covered too.
	function automatic int unsigned draw_gap(ref int unsigned burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 30);
		return $urandom_range(0, 3);
	endfunction

	// Random elements lean on the extremes and on small values, the latter so
	// that ties between row sums and between column sums come up often.
	function automatic logic signed [DEF_ELEM_W-1:0] draw_element();
		logic signed [DEF_ELEM_W-1:0] v;
		case ($urandom_range(0, 7))
			0: begin
				v = {1'b1, {(DEF_ELEM_W-1){1'b0}}};
			end
			1: begin
				v = {1'b0, {(DEF_ELEM_W-1){1'b1}}};
			end
			2, 3: begin
				v = $urandom_range(0, 6);
				v = v - 3;
			end
			default: begin
				v = DEF_ELEM_W'($urandom);
			end
		endcase
		return v;
	endfunction

	// Offer one element and hold it until the unit takes the beat.
	task automatic push_element(input logic signed [DEF_ELEM_W-1:0] value);
		int unsigned gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			elem_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_bus.valid   <= 1'b1;
		elem_bus.element <= value;
		do @(posedge clk); while (!elem_bus.ready);
		sb.accumulate_element(value);
		elements_sent++;
	endtask

	// Stream whole matrices at the current size, either a constant fill or
	// random content.
	task automatic run_matrices(input int unsigned count, input bit use_fill,
			input logic signed [DEF_ELEM_W-1:0] fill);
		int unsigned n;
		n = count * sb.eff_rows() * sb.eff_cols();
		repeat (n) push_element(use_fill ? fill : draw_element());
	endtask

	// The unit is idle once the best column beat of the last matrix has left;
	// a short pause on top covers any trailing internal activity.
	task automatic wait_drained();
		elem_bus.valid <= 1'b0;
		while (sb.sums_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Both registers are written on consecutive edges so the write enable
	// only drops once, after the second write.
	task automatic set_size(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		sb.write_reg(REG_NUM_ROWS, rows);
		cfg_index <= REG_NUM_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		sb.write_reg(REG_NUM_COLS, cols);
		cfg_we <= 1'b0;
		size_settings++;
	endtask

	// Result side: random stalls per beat, plus one long hold-off on request
	// while the element side keeps offering, so the unit backs up.
	initial begin
		int unsigned stall;
		result_t     got;
		res_bus.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = draw_gap(recv_burst);
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
			got.kind     = res_bus.kind;
			got.position = res_bus.position;
			got.total    = res_bus.total;
			got.last     = res_bus.last;
			sb.check_result(got);
		end
	end

	// Watchdog: the run is far shorter than this even with every stall.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.",
			cycle_count, sb.sums_due.size());
		$display("FAIL matrix_row_column_sum_argmax_unit");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0]        fixed_rows [3];
		logic [CFG_DATA_W-1:0]        fixed_cols [3];
		logic signed [DEF_ELEM_W-1:0] fixed_fill [3];
		logic [CFG_DATA_W-1:0]        rows;
		logic [CFG_DATA_W-1:0]        cols;
		int unsigned                  mats;

		sb = new();
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_NUM_ROWS;
		cfg_data         <= '0;
		elem_bus.valid   <= 1'b0;
		elem_bus.element <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset sizes every element is a complete one by one matrix.
		push_element({1'b1, {(DEF_ELEM_W-1){1'b0}}});
		push_element({1'b0, {(DEF_ELEM_W-1){1'b1}}});
		push_element('0);
		wait_drained();

		// Zero in both registers must behave like a size of one.
		set_size(0, 0);
		push_element(-1);
		wait_drained();

		// Two rows of three: columns one and two tie, so the first one wins.
		set_size(2, 3);
		push_element(5);
		push_element(2);
		push_element(-3);
		push_element(0);
		push_element(3);
		push_element(0);
		wait_drained();

		// Every row sum is negative, so the first row must still be taken as
		// the initial best, and the best row ends up being the last one.
		set_size(3, 2);
		push_element({1'b1, {(DEF_ELEM_W-1){1'b0}}});
		push_element({1'b1, {(DEF_ELEM_W-1){1'b0}}});
		push_element(-1);
		push_element(-2);
		push_element({1'b1, {(DEF_ELEM_W-1){1'b0}}});
		push_element({1'b0, {(DEF_ELEM_W-1){1'b1}}});
		wait_drained();

		// Oversized registers clamp to the maximum; constant extreme fills
		// drive the column and row sums to the edges of their range.
		fixed_rows = '{7'h7F, DEF_MAX_ROWS, 1};
		fixed_cols = '{1, 1, 7'h7F};
		fixed_fill = '{{1'b1, {(DEF_ELEM_W-1){1'b0}}}, {1'b0, {(DEF_ELEM_W-1){1'b1}}},
			{1'b0, {(DEF_ELEM_W-1){1'b1}}}};
		for (int k = 0; k < 3; k++) begin
			set_size(fixed_rows[k], fixed_cols[k]);
			run_matrices(1, 1'b1, fixed_fill[k]);
			wait_drained();
		end

		// Long receiver hold-off right after the first row sum, with most of
		// two matrices still to send, so the output register blocks intake.
		set_size(4, 4);
		hold_req = 1'b1;
		run_matrices(2, 1'b0, '0);
		wait_drained();

		// Random sizes and content. Tall matrices keep one column and wide
		// ones few rows so that the element count stays modest.
		while (elements_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: begin
					rows = $urandom_range(0, 127);
					cols = $urandom_range(0, 1);
				end
				1: begin
					rows = $urandom_range(0, 3);
					cols = $urandom_range(0, 127);
				end
				default: begin
					rows = $urandom_range(1, 6);
					cols = $urandom_range(1, 6);
				end
			endcase
			set_size(rows, cols);
			mats = (sb.eff_rows() * sb.eff_cols() > 16) ? 1 : $urandom_range(1, 3);
			run_matrices(mats, 1'b0, '0);
			wait_drained();
		end

		$display("Ran %0d matrices (%0d element beats) over %0d size settings, %0d results checked.",
			sb.matrices, elements_sent, size_settings, sb.checked);
		$display("Included clamped and zero sizes, extreme sums, ties and a %0d-cycle output stall.",
			HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.sums_due.size() == 0) begin
			$display("PASS matrix_row_column_sum_argmax_unit");
		end else begin
			$display("%0d mismatches, %0d results outstanding.", sb.mismatches,
				sb.sums_due.size());
			$display("FAIL matrix_row_column_sum_argmax_unit");
		end
		$finish;
	end

endmodule
